FILE: hdl/gpcc_pkg.sv
// ----------------------------------------------------------------------------
// gpcc_pkg
// shared types and constants for the gripper point collision counter
// ----------------------------------------------------------------------------
`default_nettype none

package gpcc_pkg;

	// geometry
	localparam int NUM_BOXES   = 3;
	localparam int COORD_WIDTH = 24;
	localparam int NUM_CORNERS = 4;
	localparam int NUM_EDGES   = NUM_CORNERS - 1;
	localparam int NUM_AXES    = 3;

	// arithmetic widths: differences, products, sums of three products
	localparam int DIFF_W = COORD_WIDTH + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int SUM_W  = PROD_W + 2;

	// counter widths
	localparam int LIMIT_W = 16;
	localparam int COUNT_W = LIMIT_W + 1;
	localparam logic [LIMIT_W-1:0] HIT_LIMIT_RST = LIMIT_W'(100);

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// command codes on the item channel
	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_TEST = 2'd1;
	localparam logic [1:0] CMD_END  = 2'd2;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_TEST,
		OP_END
	} op_t;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct packed {
		logic [1:0] command;
		logic [1:0] box_index;
		logic [1:0] corner_index;
		coord_t     coord_x;
		coord_t     coord_y;
		coord_t     coord_z;
		logic       point_valid;
	} item_t;

	typedef struct packed {
		logic               point_collides;
		logic [COUNT_W-1:0] hit_count;
		logic               pose_rejected;
		logic               pose_done;
	} result_t;

	// classified entry held in the queue
	typedef struct packed {
		op_t        op;
		logic [1:0] box_index;
		logic [1:0] corner_index;
		coord_t     coord_x;
		coord_t     coord_y;
		coord_t     coord_z;
		logic       point_valid;
	} qent_t;

	// queue head handed from front to back
	typedef struct packed {
		logic  valid;
		qent_t ent;
	} qhead_t;

endpackage

`default_nettype wire

FILE: hdl/gpcc_front.sv
// ----------------------------------------------------------------------------
// gpcc_front
// accepts item beats, decodes the command and queues the work for the back
// ----------------------------------------------------------------------------
`default_nettype none

module gpcc_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire gpcc_pkg::item_t item,
	input  wire logic            item_valid,
	output logic                 item_stall,
	output gpcc_pkg::qhead_t     head,
	input  wire logic            pop
);
	import gpcc_pkg::*;

	qent_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	logic  keep;
	op_t   op;
	logic  push;
	qent_t ent;

	// command decode: drop unused codes and loads to boxes that do not exist
	always_comb begin
		keep = 1'b0;
		op   = OP_TEST;
		unique case (item.command)
			CMD_LOAD: begin
				op   = OP_LOAD;
				keep = int'(item.box_index) < NUM_BOXES;
			end
			CMD_TEST: begin
				op   = OP_TEST;
				keep = 1'b1;
			end
			CMD_END: begin
				op   = OP_END;
				keep = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	always_comb begin
		ent.op           = op;
		ent.box_index    = item.box_index;
		ent.corner_index = item.corner_index;
		ent.coord_x      = item.coord_x;
		ent.coord_y      = item.coord_y;
		ent.coord_z      = item.coord_z;
		ent.point_valid  = item.point_valid;
	end

	assign item_stall = (cnt_q == QCNT_W'(QDEPTH));
	assign push       = item_valid && !item_stall && keep;

	assign head.valid = (cnt_q != '0);
	assign head.ent   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= ent;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/gpcc_back.sv
// ----------------------------------------------------------------------------
// gpcc_back
// corner store, box test pipeline, hit tally and result register
// ----------------------------------------------------------------------------
`default_nettype none

module gpcc_back (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire gpcc_pkg::qhead_t                 head,
	output logic                                  pop,
	input  wire logic [gpcc_pkg::LIMIT_W-1:0]     hit_limit,
	output gpcc_pkg::result_t                     result,
	output logic                                  result_valid,
	input  wire logic                             result_stall
);
	import gpcc_pkg::*;

	coord_t corner_q [NUM_BOXES][NUM_CORNERS][NUM_AXES];

	logic                     en;
	coord_t                   pt [NUM_AXES];
	logic signed [DIFF_W-1:0] d  [NUM_BOXES][NUM_AXES];
	logic signed [DIFF_W-1:0] e  [NUM_BOXES][NUM_EDGES][NUM_AXES];

	// stage 1: differences
	logic                     vld_s1;
	op_t                      op_s1;
	logic                     pv_s1;
	logic signed [DIFF_W-1:0] d_s1 [NUM_BOXES][NUM_AXES];
	logic signed [DIFF_W-1:0] e_s1 [NUM_BOXES][NUM_EDGES][NUM_AXES];

	// stage 2: products
	logic                     vld_s2;
	op_t                      op_s2;
	logic                     pv_s2;
	logic signed [PROD_W-1:0] pd_s2 [NUM_BOXES][NUM_EDGES][NUM_AXES];
	logic signed [PROD_W-1:0] pl_s2 [NUM_BOXES][NUM_EDGES][NUM_AXES];

	// stage 3: dot products and squared lengths
	logic                    vld_s3;
	op_t                     op_s3;
	logic                    pv_s3;
	logic signed [SUM_W-1:0] dot_s3 [NUM_BOXES][NUM_EDGES];
	logic signed [SUM_W-1:0] len_s3 [NUM_BOXES][NUM_EDGES];

	// stage 4: hit decision
	logic vld_s4;
	op_t  op_s4;
	logic pv_s4;
	logic hit_s4;
	logic hit_any;

	// tally
	logic [COUNT_W-1:0] tally_q;
	logic               rej_q;
	logic [COUNT_W-1:0] limit_ext;
	logic [COUNT_W-1:0] tally_nxt;
	logic               rej_nxt;
	logic               inc;

	assign en  = !result_valid || !result_stall;
	assign pop = head.valid && en;

	assign pt[0] = head.ent.coord_x;
	assign pt[1] = head.ent.coord_y;
	assign pt[2] = head.ent.coord_z;

	always_comb begin
		for (int b = 0; b < NUM_BOXES; b++) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				d[b][i] = DIFF_W'(pt[i]) - DIFF_W'(corner_q[b][0][i]);
				for (int k = 0; k < NUM_EDGES; k++) begin
					e[b][k][i] = DIFF_W'(corner_q[b][k+1][i]) - DIFF_W'(corner_q[b][0][i]);
				end
			end
		end
	end

	// corner writes happen in queue order, so tests see every earlier load
	always_ff @(posedge clk) begin
		if (pop && head.ent.op == OP_LOAD) begin
			for (int b = 0; b < NUM_BOXES; b++) begin
				if (int'(head.ent.box_index) == b) begin
					for (int i = 0; i < NUM_AXES; i++) begin
						corner_q[b][head.ent.corner_index][i] <= pt[i];
					end
				end
			end
		end
	end

	// inside test: every dot product in [0, squared edge length]
	always_comb begin
		hit_any = 1'b0;
		for (int b = 0; b < NUM_BOXES; b++) begin
			logic in_box;
			in_box = 1'b1;
			for (int k = 0; k < NUM_EDGES; k++) begin
				if (dot_s3[b][k] < 0 || dot_s3[b][k] > len_s3[b][k]) begin
					in_box = 1'b0;
				end
			end
			hit_any = hit_any | in_box;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= head.ent.op;
			pv_s1 <= head.ent.point_valid;
			d_s1  <= d;
			e_s1  <= e;

			op_s2 <= op_s1;
			pv_s2 <= pv_s1;
			for (int b = 0; b < NUM_BOXES; b++) begin
				for (int k = 0; k < NUM_EDGES; k++) begin
					for (int i = 0; i < NUM_AXES; i++) begin
						pd_s2[b][k][i] <= PROD_W'(d_s1[b][i]) * PROD_W'(e_s1[b][k][i]);
						pl_s2[b][k][i] <= PROD_W'(e_s1[b][k][i]) * PROD_W'(e_s1[b][k][i]);
					end
				end
			end

			op_s3 <= op_s2;
			pv_s3 <= pv_s2;
			for (int b = 0; b < NUM_BOXES; b++) begin
				for (int k = 0; k < NUM_EDGES; k++) begin
					dot_s3[b][k] <= SUM_W'(pd_s2[b][k][0]) + SUM_W'(pd_s2[b][k][1])
						+ SUM_W'(pd_s2[b][k][2]);
					len_s3[b][k] <= SUM_W'(pl_s2[b][k][0]) + SUM_W'(pl_s2[b][k][1])
						+ SUM_W'(pl_s2[b][k][2]);
				end
			end

			op_s4  <= op_s3;
			pv_s4  <= pv_s3;
			hit_s4 <= hit_any && pv_s3;
		end
	end

	// tally update as an item leaves stage 4
	assign limit_ext = COUNT_W'(hit_limit);
	assign inc       = hit_s4 && (tally_q <= limit_ext);
	assign tally_nxt = tally_q + COUNT_W'(inc);
	assign rej_nxt   = rej_q || (pv_s4 && (tally_nxt > limit_ext));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1       <= 1'b0;
			vld_s2       <= 1'b0;
			vld_s3       <= 1'b0;
			vld_s4       <= 1'b0;
			result_valid <= 1'b0;
			tally_q      <= '0;
			rej_q        <= 1'b0;
		end else if (en) begin
			vld_s1       <= pop && head.ent.op != OP_LOAD;
			vld_s2       <= vld_s1;
			vld_s3       <= vld_s2;
			vld_s4       <= vld_s3;
			result_valid <= vld_s4;
			if (vld_s4) begin
				if (op_s4 == OP_END) begin
					tally_q <= '0;
					rej_q   <= 1'b0;
				end else begin
					tally_q <= tally_nxt;
					rej_q   <= rej_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld_s4) begin
			if (op_s4 == OP_END) begin
				result.point_collides <= 1'b0;
				result.hit_count      <= tally_q;
				result.pose_rejected  <= rej_q;
				result.pose_done      <= 1'b1;
			end else begin
				result.point_collides <= hit_s4;
				result.hit_count      <= tally_nxt;
				result.pose_rejected  <= rej_nxt;
				result.pose_done      <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hdl/gripper_point_collision_counter.sv
// ----------------------------------------------------------------------------
// gripper_point_collision_counter
// counts streamed points inside any of three oriented gripper boxes
// ----------------------------------------------------------------------------
// usage
//   item channel (item, item_valid, item_stall): one beat per command
//     load corner: writes one corner of one box, gives no result
//     test point : gives one result with the hit flag, count and verdict
//     end of pose: gives one result with pose_done set, then clears the count
//   result channel (result, result_valid, result_stall): one beat per test/end
//   hit_limit_we / hit_limit_wdata: writes the limit; the user writes it only
//   while idle, and the block itself does not enforce it
// pipeline
//   queue, differences, products, sums, compare, result register; one item
//   per cycle while the result channel is not stalled; the back pipeline
//   runs the dot products and squared lengths of every edge of every box in
//   parallel, so nothing recirculates
// reset
//   clears queue, pipeline valids, count and verdict; limit returns to 100;
//   box corners hold nothing until loaded
// stall
//   a stalled result freezes the back pipeline; the front keeps taking beats
//   into a four-entry queue and raises item_stall only when that queue fills
// ----------------------------------------------------------------------------
`default_nettype none

module gripper_point_collision_counter (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire gpcc_pkg::item_t              item,
	input  wire logic                         item_valid,
	output logic                              item_stall,
	output gpcc_pkg::result_t                 result,
	output logic                              result_valid,
	input  wire logic                         result_stall,
	input  wire logic                         hit_limit_we,
	input  wire logic [gpcc_pkg::LIMIT_W-1:0] hit_limit_wdata
);
	import gpcc_pkg::*;

	logic [LIMIT_W-1:0] hit_limit_q;
	qhead_t             head;
	logic               pop;

	// limit register; the user writes it only while idle, unchecked by the block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_limit_q <= HIT_LIMIT_RST;
		end else if (hit_limit_we) begin
			hit_limit_q <= hit_limit_wdata;
		end
	end

	// front: decode and queue every beat that does work
	gpcc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.head       (head),
		.pop        (pop)
	);

	// back: corner loads in order, box tests, tally and result beat
	gpcc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.hit_limit    (hit_limit_q),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

endmodule

`default_nettype wire

FILE: sim/gpcc_checker.sv
// ----------------------------------------------------------------------------
// gpcc_checker
// watches both channels and the limit port of the collision counter, keeps
// its own copy of the box corners, hit tally and verdict, works out the
// result of every accepted beat and compares it field by field
// ----------------------------------------------------------------------------

module gpcc_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  gpcc_pkg::item_t              item,
	input  logic                         item_valid,
	input  logic                         item_stall,
	input  gpcc_pkg::result_t            result,
	input  logic                         result_valid,
	input  logic                         result_stall,
	input  logic                         hit_limit_we,
	input  logic [gpcc_pkg::LIMIT_W-1:0] hit_limit_wdata,
	output int                           fail_count,
	output int                           results_pending
);

	timeunit 1ns;
	timeprecision 1ps;

	import gpcc_pkg::*;

	coord_t             corners [NUM_BOXES][NUM_CORNERS][NUM_AXES];
	logic [LIMIT_W-1:0] limit;
	logic [COUNT_W-1:0] tally;
	logic               rejected;
	result_t            awaited [$];
	int                 fails;

	// point inside box when every edge projection lies in [0, |edge|^2]
	function automatic logic inside_box(input int b, input coord_t pt [NUM_AXES]);
		longint rel [NUM_AXES];
		longint e, dot, len;
		for (int i = 0; i < NUM_AXES; i++)
			rel[i] = longint'(pt[i]) - longint'(corners[b][0][i]);
		for (int k = 1; k < NUM_CORNERS; k++) begin
			dot = 0;
			len = 0;
			for (int i = 0; i < NUM_AXES; i++) begin
				e = longint'(corners[b][k][i]) - longint'(corners[b][0][i]);
				dot += rel[i] * e;
				len += e * e;
			end
			if (dot < 0 || dot > len)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void compare_field(input string name,
			input logic [COUNT_W-1:0] want, input logic [COUNT_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		coord_t  pt [NUM_AXES];
		logic    hit;
		if (!arst_n) begin
			awaited.delete();
			tally    = '0;
			rejected = 1'b0;
			limit    = HIT_LIMIT_RST;
			fails    = 0;
		end else begin
			// result side first: an item taken on this edge cannot answer yet
			if (result_valid && !result_stall) begin
				if (awaited.size() == 0) begin
					$error("unexpected result beat: collides %0d count %0d rejected %0d done %0d",
						result.point_collides, result.hit_count, result.pose_rejected,
						result.pose_done);
					fails++;
				end else begin
					want = awaited.pop_front();
					compare_field("point_collides", COUNT_W'(want.point_collides),
						COUNT_W'(result.point_collides));
					compare_field("hit_count", want.hit_count, result.hit_count);
					compare_field("pose_rejected", COUNT_W'(want.pose_rejected),
						COUNT_W'(result.pose_rejected));
					compare_field("pose_done", COUNT_W'(want.pose_done),
						COUNT_W'(result.pose_done));
				end
			end
			if (hit_limit_we)
				limit = hit_limit_wdata;
			if (item_valid && !item_stall) begin
				pt[0] = item.coord_x;
				pt[1] = item.coord_y;
				pt[2] = item.coord_z;
				case (item.command)
					CMD_LOAD: begin
						if (int'(item.box_index) < NUM_BOXES)
							corners[item.box_index][item.corner_index] = pt;
					end
					CMD_TEST: begin
						hit = 1'b0;
						if (item.point_valid) begin
							for (int b = 0; b < NUM_BOXES; b++)
								if (inside_box(b, pt))
									hit = 1'b1;
							if (hit && tally <= {1'b0, limit})
								tally++;
							if (tally > {1'b0, limit})
								rejected = 1'b1;
						end
						want = '{point_collides: hit, hit_count: tally,
							pose_rejected: rejected, pose_done: 1'b0};
						awaited = {awaited, want};
					end
					CMD_END: begin
						want = '{point_collides: 1'b0, hit_count: tally,
							pose_rejected: rejected, pose_done: 1'b1};
						awaited = {awaited, want};
						tally    = '0;
						rejected = 1'b0;
					end
					default: ;
				endcase
			end
		end
		results_pending <= awaited.size();
		fail_count      <= fails;
	end

endmodule

FILE: sim/tb_gripper_point_collision_counter.sv
// ----------------------------------------------------------------------------
// tb_gripper_point_collision_counter
// drives box corner loads, point tests and end-of-pose beats into the
// collision counter under random gaps and result stalls, with a short
// directed opening and then random poses under changing hit limits; the
// checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------

module tb_gripper_point_collision_counter;

	timeunit 1ns;
	timeprecision 1ps;

	import gpcc_pkg::*;

	localparam int ITEM_TARGET = 1100;
	localparam int LONG_HOLD   = 80;   // receiver hold-off used to fill the queue
	localparam int DRAIN_WAIT  = 10;   // pipeline is 6 deep, loads give no beat
	localparam int ITEM_W      = $bits(item_t);

	// codes the package does not name
	localparam logic [1:0] CMD_SPARE  = 2'd3;
	localparam logic [1:0] BOX_PALM   = 2'd0;
	localparam logic [1:0] BOX_LEFT   = 2'd1;
	localparam logic [1:0] BOX_RIGHT  = 2'd2;
	localparam logic [1:0] BOX_NONE   = 2'(NUM_BOXES);

	localparam coord_t CMAX_C = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam coord_t CMIN_C = {1'b1, {(COORD_WIDTH-1){1'b0}}};
	localparam longint CMAX   = longint'(CMAX_C);
	localparam longint CMIN   = longint'(CMIN_C);

	logic               clk;
	logic               arst_n;
	item_t              item;
	logic               item_valid;
	logic               item_stall;
	result_t            result;
	logic               result_valid;
	logic               result_stall;
	logic               hit_limit_we;
	logic [LIMIT_W-1:0] hit_limit_wdata;

	int fail_count;
	int results_pending;
	int hold_requests;  // bumped by stimulus, served by the stall process
	int sent_items;     // beats that do something, ignored codes not counted
	bit no_gaps;        // back-to-back phase on the item side

	// shape of each box as last loaded, used only to aim points
	longint org  [NUM_BOXES][NUM_AXES];
	longint span [NUM_BOXES][NUM_EDGES][NUM_AXES];

	initial clk = 1'b0;
	always #5 clk = ~clk;

	gripper_point_collision_counter i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.item            (item),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.result          (result),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.hit_limit_we    (hit_limit_we),
		.hit_limit_wdata (hit_limit_wdata)
	);

	gpcc_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.item            (item),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.result          (result),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.hit_limit_we    (hit_limit_we),
		.hit_limit_wdata (hit_limit_wdata),
		.fail_count      (fail_count),
		.results_pending (results_pending)
	);

	// watchdog, several times the slowest legal run
	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// uniform in [-lim, lim]
	function automatic longint spread(input longint lim);
		return longint'($urandom_range(0, 32'(2 * lim))) - lim;
	endfunction

	function automatic coord_t clamp_coord(input longint v);
		if (v > CMAX)
			return CMAX_C;
		if (v < CMIN)
			return CMIN_C;
		return coord_t'(v);
	endfunction

	// receiver side: random stall bursts, quiet stretches, and long holds on request
	initial begin : stall_gen
		int   left;
		int   holds_served;
		logic stalled;
		result_stall = 1'b0;
		left         = 0;
		holds_served = 0;
		stalled      = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != holds_served) begin
				// long hold-off so the queue fills and item_stall rises
				holds_served++;
				result_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				result_stall <= 1'b0;
				stalled = 1'b0;
				left    = $urandom_range(1, 8);
			end else if (left > 0) begin
				left--;
			end else if (stalled) begin
				stalled = 1'b0;
				result_stall <= 1'b0;
				left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
					: $urandom_range(0, 12);
			end else begin
				stalled = 1'b1;
				result_stall <= 1'b1;
				left = pick_gap();
			end
		end
	end

	// one beat on the item channel; valid stays up afterwards so a following
	// call with no gap runs back to back
	task automatic send(input logic [1:0] cmd, input logic [1:0] bx, input logic [1:0] cn,
			input coord_t x, input coord_t y, input coord_t z, input logic pv);
		int          gap;
		logic [95:0] noise_bits;
		gap = no_gaps ? 0 : pick_gap();
		repeat (gap) begin
			@(negedge clk);
			noise_bits = {$urandom(), $urandom(), $urandom()};
			item       <= item_t'(noise_bits[ITEM_W-1:0]);
			item_valid <= 1'b0;
		end
		@(negedge clk);
		item <= '{command: cmd, box_index: bx, corner_index: cn,
			coord_x: x, coord_y: y, coord_z: z, point_valid: pv};
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		if (cmd == CMD_TEST || cmd == CMD_END || (cmd == CMD_LOAD && bx != BOX_NONE))
			sent_items++;
	endtask

	// wait until every expected beat is back, then let loads clear the pipe
	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (results_pending != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] v);
		@(negedge clk);
		hit_limit_we    <= 1'b1;
		hit_limit_wdata <= v;
		@(negedge clk);
		hit_limit_we    <= 1'b0;
	endtask

	// new random box: axis aligned, rotated, skewed or collapsed to a point
	task automatic load_box(input int b);
		longint cr [NUM_CORNERS][NUM_AXES];
		longint lim, a, d, sc;
		int     kind, rot, first, k, i;
		kind = $urandom_range(0, 19);
		lim  = longint'(1) << $urandom_range(0, 18);
		for (i = 0; i < NUM_AXES; i++)
			org[b][i] = ($urandom_range(0, 9) == 0) ? spread(CMAX) : spread(longint'(1) << 22);
		for (k = 0; k < NUM_EDGES; k++)
			for (i = 0; i < NUM_AXES; i++)
				span[b][k][i] = 0;
		if (kind == 0) begin
			// all four corners coincide
		end else if (kind <= 8) begin
			for (k = 0; k < NUM_EDGES; k++)
				span[b][k][k] = spread(lim);
		end else if (kind <= 14) begin
			// integer rotation in one plane keeps the edges orthogonal
			rot = $urandom_range(0, 2);
			sc  = (lim >> 10) + 1;
			a   = spread(1024) * sc;
			d   = spread(1024) * sc;
			span[b][0][rot]           = a;
			span[b][0][(rot + 1) % 3] = d;
			span[b][1][rot]           = -d;
			span[b][1][(rot + 1) % 3] = a;
			span[b][2][(rot + 2) % 3] = spread(lim);
		end else begin
			for (k = 0; k < NUM_EDGES; k++)
				for (i = 0; i < NUM_AXES; i++)
					span[b][k][i] = spread(lim);
		end
		for (i = 0; i < NUM_AXES; i++) begin
			cr[0][i]  = clamp_coord(org[b][i]);
			org[b][i] = cr[0][i];
		end
		for (k = 1; k < NUM_CORNERS; k++)
			for (i = 0; i < NUM_AXES; i++) begin
				cr[k][i]          = clamp_coord(org[b][i] + span[b][k-1][i]);
				span[b][k-1][i]   = cr[k][i] - org[b][i];
			end
		first = $urandom_range(0, NUM_CORNERS - 1);
		for (k = 0; k < NUM_CORNERS; k++) begin
			i = (first + k) % NUM_CORNERS;
			send(CMD_LOAD, 2'(b), 2'(i), coord_t'(cr[i][0]), coord_t'(cr[i][1]),
				coord_t'(cr[i][2]), 1'($urandom_range(0, 1)));
		end
	endtask

	// point aimed inside, on the faces, around, or anywhere
	task automatic send_point();
		longint f [NUM_EDGES];
		longint p [NUM_AXES];
		int     b, r, k, i;
		b = $urandom_range(0, NUM_BOXES - 1);
		r = $urandom_range(0, 99);
		for (k = 0; k < NUM_EDGES; k++) begin
			if (r < 45)
				f[k] = $urandom_range(0, 4096);
			else if (r < 60)
				f[k] = 4096 * longint'($urandom_range(0, 1));
			else
				f[k] = longint'($urandom_range(0, 8192)) - 2048;
		end
		for (i = 0; i < NUM_AXES; i++) begin
			p[i] = org[b][i];
			for (k = 0; k < NUM_EDGES; k++)
				p[i] += f[k] * span[b][k][i] / 4096;
		end
		// corners and faces, nudged one lsb either way
		if (r >= 45 && r < 60)
			p[$urandom_range(0, 2)] += longint'($urandom_range(0, 2)) - 1;
		if (r >= 80)
			for (i = 0; i < NUM_AXES; i++)
				p[i] = longint'(coord_t'($urandom()));
		send(CMD_TEST, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
			clamp_coord(p[0]), clamp_coord(p[1]), clamp_coord(p[2]),
			1'($urandom_range(0, 9) != 0));
	endtask

	initial begin : stimulus
		coord_t pq, sx;
		int     pose_no, n_tests, r, b;
		logic [LIMIT_W-1:0] lim_val;

		arst_n          = 1'b0;
		item            = '0;
		item_valid      = 1'b0;
		hit_limit_we    = 1'b0;
		hit_limit_wdata = '0;
		hold_requests   = 0;
		sent_items      = 0;
		no_gaps         = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// ---- directed opening, limit at its reset value ----
		// palm covers the far negative octant up to x = -1, full extremes on y and z
		send(CMD_LOAD, BOX_PALM, 2'd0, CMIN_C, CMIN_C, CMIN_C, 1'b0);
		send(CMD_LOAD, BOX_PALM, 2'd1, -24'sd1, CMIN_C, CMIN_C, 1'b1);
		send(CMD_LOAD, BOX_PALM, 2'd2, CMIN_C, CMAX_C, CMIN_C, 1'b0);
		send(CMD_LOAD, BOX_PALM, 2'd3, CMIN_C, CMIN_C, CMAX_C, 1'b1);
		// left finger collapsed to one point
		for (int k = 0; k < NUM_CORNERS; k++)
			send(CMD_LOAD, BOX_LEFT, 2'(k), 24'sd1000, -24'sd2000, 24'sd3000, 1'b1);
		// right finger rotated about z, edges from a Pythagorean triple, all of equal length
		pq = 24'sd131072;
		sx = 24'sd4096;
		send(CMD_LOAD, BOX_RIGHT, 2'd0, pq, pq, pq, 1'b0);
		send(CMD_LOAD, BOX_RIGHT, 2'd1, coord_t'(pq + 3 * sx), coord_t'(pq + 4 * sx), pq,
			1'b0);
		send(CMD_LOAD, BOX_RIGHT, 2'd2, coord_t'(pq - 4 * sx), coord_t'(pq + 3 * sx), pq,
			1'b1);
		send(CMD_LOAD, BOX_RIGHT, 2'd3, pq, pq, coord_t'(pq + 5 * sx), 1'b1);
		// box index past the last box and the spare command: both dropped
		send(CMD_LOAD, BOX_NONE, 2'd0, CMAX_C, CMAX_C, CMAX_C, 1'b1);
		send(CMD_SPARE, 2'd3, 2'd3, CMAX_C, CMAX_C, CMAX_C, 1'b1);
		// palm origin corner, then the far corner exactly on all three faces
		send(CMD_TEST, 2'd0, 2'd0, CMIN_C, CMIN_C, CMIN_C, 1'b1);
		send(CMD_TEST, 2'd3, 2'd3, -24'sd1, CMAX_C, CMAX_C, 1'b1);
		// one lsb past the palm face
		send(CMD_TEST, 2'd1, 2'd2, 24'sd0, CMIN_C, CMIN_C, 1'b1);
		// collapsed finger hit at its single point, then same point flagged invalid
		send(CMD_TEST, 2'd2, 2'd1, 24'sd1000, -24'sd2000, 24'sd3000, 1'b1);
		send(CMD_TEST, 2'd2, 2'd1, 24'sd1000, -24'sd2000, 24'sd3000, 1'b0);
		send(CMD_TEST, 2'd0, 2'd0, CMAX_C, CMAX_C, CMAX_C, 1'b1);
		send(CMD_TEST, 2'd1, 2'd1, pq, pq, pq, 1'b1);
		send(CMD_END, 2'd0, 2'd0, CMAX_C, CMIN_C, CMAX_C, 1'b1);

		// limit 0: first hit rejects, count saturates, rejection sticks on a miss
		drain();
		write_limit('0);
		send(CMD_TEST, 2'd0, 2'd0, 24'sd1000, -24'sd2000, 24'sd3000, 1'b1);
		send(CMD_TEST, 2'd0, 2'd0, CMIN_C, CMIN_C, CMIN_C, 1'b1);
		send(CMD_TEST, 2'd0, 2'd0, 24'sd0, 24'sd0, 24'sd0, 1'b1);
		send(CMD_END, 2'd3, 2'd3, 24'sd0, 24'sd0, 24'sd0, 1'b0);

		// ---- random poses ----
		pose_no = 0;
		while (sent_items < ITEM_TARGET) begin
			// limit changes only with the block idle
			if (pose_no == 1 || $urandom_range(0, 1) == 0) begin
				r = $urandom_range(0, 9);
				if (pose_no == 1 || r == 2)
					lim_val = '1;
				else if (r == 0)
					lim_val = '0;
				else if (r == 1)
					lim_val = LIMIT_W'(1);
				else if (r == 3)
					lim_val = HIT_LIMIT_RST;
				else if (r == 7)
					lim_val = LIMIT_W'($urandom_range(0, 65535));
				else
					lim_val = LIMIT_W'($urandom_range(2, 30));
				drain();
				write_limit(lim_val);
			end
			no_gaps = ($urandom_range(0, 3) == 0);
			// every fifth pose starts under a long result hold-off at full rate
			if (pose_no % 5 == 2) begin
				hold_requests <= hold_requests + 1;
				no_gaps = 1'b1;
			end
			for (b = 0; b < NUM_BOXES; b++)
				if (pose_no == 0 || $urandom_range(0, 4) != 0)
					load_box(b);
			n_tests = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(10, 60);
			repeat (n_tests) begin
				r = $urandom_range(0, 39);
				if (r == 0)
					send(CMD_SPARE, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
						coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()),
						1'($urandom_range(0, 1)));
				else if (r == 1)
					send(CMD_LOAD, BOX_NONE, 2'($urandom_range(0, 3)),
						coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()),
						1'($urandom_range(0, 1)));
				send_point();
			end
			send(CMD_END, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
				coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()),
				1'($urandom_range(0, 1)));
			pose_no++;
		end

		drain();
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
